// ----- rtl/core/ndr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ndr_pkg;

    // Q16.16 and Q1.16 unity.
    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Configuration register indexes.
    localparam int          CFG_AW        = 1;
    localparam logic [0:0]  REG_DISCOUNT  = 1'd0;
    localparam logic [0:0]  REG_LOOKAHEAD = 1'd1;

    typedef enum logic [7:0] {
        S_LOAD = 8'b0000_0001,
        S_BRD  = 8'b0000_0010,
        S_BADD = 8'b0000_0100,
        S_PMUL = 8'b0000_1000,
        S_PWR  = 8'b0001_0000,
        S_ERD  = 8'b0010_0000,
        S_EMUL = 8'b0100_0000,
        S_EADD = 8'b1000_0000
    } t_state;

    // Request to the shared multiplier: product = (factor * value) >>> 16.
    typedef struct packed {
        logic               en;
        logic [16:0]        factor;
        logic signed [31:0] value;
    } t_mul_req;

    // Add or subtract two Q16.16 values and clamp to the 32-bit range.
    function automatic logic signed [31:0] sat_add(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic               sub
    );
        logic signed [33:0] s;
        s = sub ? (34'(a) - 34'(b)) : (34'(a) + 34'(b));
        if (s > 34'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (s < -34'sd2147483648) begin
            return 32'sh8000_0000;
        end else begin
            return s[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ndr_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ndr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- rtl/core/ndr_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ndr_mul (
    input  wire logic              i_clk,
    input  wire ndr_pkg::t_mul_req i_req,
    output logic signed [31:0]     o_prod
);

    logic signed [49:0] w_full;
    logic signed [31:0] r_prod;

    // The factor never exceeds 1.0, so the shifted product fits in 32 bits.
    // The arithmetic shift rounds toward minus infinity.
    assign w_full = $signed({1'b0, i_req.factor}) * i_req.value;

    always_ff @(posedge i_clk) begin
        if (i_req.en) begin
            r_prod <= w_full[47:16];
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ----- rtl/core/nstep_discounted_return_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// N-step discounted return unit.
// Rewards of one episode arrive on the slave stream, one word each; tlast
// marks the last reward, and that word also carries the bootstrap (rollout)
// value. Loading takes one word per cycle. After the last word the unit runs
// three passes on one shared 17x32 multiplier: a backward pass that forms the
// discounted sums (multiply, then add per step), a pass that tabulates the
// powers of the discount (multiply, then write per step) and an emit pass
// that writes one result word per step on the master stream (read, multiply,
// add per step). The passes are bounded by the multiplier and the single read port of
// the sum memory. The slave side is not ready from the last word until the
// final result has been loaded into the output register; that register lets
// the next episode start loading while the final result still waits. A
// stalled receiver holds the emit pass. Rewards beyond MAX_LEN are dropped and
// every result of that episode carries the overflow flag. Reset clears the
// sequencer, the episode length, the drop flag and the output valid flag, and
// sets discount to 1.0 and lookahead to 1; the memories need no clearing
// because every entry read was written earlier in the same episode. Register
// writes take effect at once; an episode uses the values present when its
// last word is accepted.
module nstep_discounted_return_unit #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration: index 0 is discount (Q1.16), index 1 is lookahead.
    input  wire logic                         i_cfg_we,
    input  wire logic [ndr_pkg::CFG_AW-1:0]   i_cfg_addr,
    input  wire logic [16:0]                  i_cfg_data,
    // Input words.
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [63:0]                  s_axis_tdata,  // reward, rollout_value
    input  wire logic                         s_axis_tlast,  // episode_end
    // Result words.
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [47:0]                       m_axis_tdata,  // step_index, n_step_return,
                                                             // next_state_index, zero pad
    output logic [1:0]                        m_axis_tuser,  // terminal, overflow
    output logic                              m_axis_tlast   // last_result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int LW = $clog2(MAX_LEN + 1);

    ndr_pkg::t_state r_state;
    ndr_pkg::t_state n_state;

    // Configuration registers.
    logic [16:0]        r_discount;
    logic [6:0]         r_lookahead;

    // Episode bookkeeping.
    logic [LW-1:0]      r_len;
    logic               r_drop;
    logic [LW-1:0]      r_t;
    logic               r_ovf;
    logic signed [31:0] r_rollout;
    logic [16:0]        r_gamma;
    logic [LW-1:0]      r_n;

    // Pass state.
    logic [AW-1:0]      r_idx;
    logic               r_first;
    logic signed [31:0] r_acc;
    logic [16:0]        r_pw;
    logic [LW-1:0]      r_k;
    logic [16:0]        r_pn;

    // Output register.
    logic               r_ovalid;
    logic [5:0]         r_o_step;
    logic signed [31:0] r_o_ret;
    logic               r_o_term;
    logic [5:0]         r_o_next;
    logic               r_o_ovf;
    logic               r_o_last;

    logic               w_in_acc;
    logic               w_store;
    logic [LW-1:0]      w_len_inc;
    logic [LW-1:0]      w_t_new;
    logic [16:0]        w_gamma;
    logic [LW-1:0]      w_n;
    logic [LW:0]        w_ahead;
    logic               w_term;
    logic [LW-1:0]      w_pw_off;
    logic [LW-1:0]      w_k_m1;
    logic               w_last;
    logic               w_slot;
    logic [AW-1:0]      w_cum_raddr;
    logic signed [31:0] w_bsum;
    logic signed [31:0] w_ret;

    logic [31:0]        w_rew_rdata;
    logic [31:0]        w_cum_rdata;
    logic [16:0]        w_pw_rdata;
    logic signed [31:0] w_prod;
    ndr_pkg::t_mul_req  w_req;

    assign s_axis_tready = (r_state == ndr_pkg::S_LOAD);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_store       = (r_len < LW'(MAX_LEN));
    assign w_len_inc     = r_len + LW'(1);
    assign w_t_new       = w_store ? w_len_inc : r_len;

    // Discount above 1.0 acts as 1.0; lookahead is held to 1..MAX_LEN.
    assign w_gamma = (r_discount > ndr_pkg::ONE_Q16) ? ndr_pkg::ONE_Q16 : r_discount;
    always_comb begin
        if (r_lookahead == 7'd0) begin
            w_n = LW'(1);
        end else if (r_lookahead > 7'(MAX_LEN)) begin
            w_n = LW'(MAX_LEN);
        end else begin
            w_n = LW'(r_lookahead);
        end
    end

    // A step is terminal when its lookahead window reaches the episode end.
    assign w_ahead  = (LW+1)'(r_idx) + (LW+1)'(r_n);
    assign w_term   = (w_ahead >= (LW+1)'(r_t));
    assign w_pw_off = r_t - LW'(1) - LW'(r_idx);
    assign w_k_m1   = r_k - LW'(1);
    assign w_last   = (LW'(r_idx) == (r_t - LW'(1)));
    assign w_slot   = !r_ovalid || m_axis_tready;

    // For a non-terminal step the sum memory reads the far entry first, then the step's own entry.
    assign w_cum_raddr = (r_state == ndr_pkg::S_ERD && !w_term) ? w_ahead[AW-1:0] : r_idx;

    assign w_bsum = ndr_pkg::sat_add($signed(w_rew_rdata), w_prod, 1'b0);
    assign w_ret  = ndr_pkg::sat_add($signed(w_cum_rdata), w_prod, !w_term);

    // Operand selection for the shared multiplier.
    always_comb begin
        w_req.en     = 1'b0;
        w_req.factor = r_gamma;
        w_req.value  = r_acc;
        unique case (r_state)
            ndr_pkg::S_BRD: begin
                w_req.en    = 1'b1;
                w_req.value = r_first ? 32'sd0 : r_acc;
            end
            ndr_pkg::S_PMUL: begin
                w_req.en    = 1'b1;
                w_req.value = $signed(32'(r_pw));
            end
            ndr_pkg::S_EMUL: begin
                w_req.en = 1'b1;
                if (w_term) begin
                    w_req.factor = w_pw_rdata;
                    w_req.value  = r_rollout;
                end else begin
                    w_req.factor = r_pn;
                    w_req.value  = $signed(w_cum_rdata);
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ndr_pkg::S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    n_state = ndr_pkg::S_BRD;
                end
            end
            ndr_pkg::S_BRD:  n_state = ndr_pkg::S_BADD;
            ndr_pkg::S_BADD: n_state = (r_idx == '0) ? ndr_pkg::S_PMUL : ndr_pkg::S_BRD;
            ndr_pkg::S_PMUL: n_state = ndr_pkg::S_PWR;
            ndr_pkg::S_PWR:  n_state = (r_k == r_t) ? ndr_pkg::S_ERD : ndr_pkg::S_PMUL;
            ndr_pkg::S_ERD:  n_state = ndr_pkg::S_EMUL;
            ndr_pkg::S_EMUL: n_state = ndr_pkg::S_EADD;
            ndr_pkg::S_EADD: begin
                if (w_slot) begin
                    n_state = w_last ? ndr_pkg::S_LOAD : ndr_pkg::S_ERD;
                end
            end
            default: n_state = ndr_pkg::S_LOAD;
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ndr_pkg::S_LOAD;
            r_discount  <= ndr_pkg::ONE_Q16;
            r_lookahead <= 7'd1;
            r_len       <= '0;
            r_drop      <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    ndr_pkg::REG_DISCOUNT:  r_discount  <= i_cfg_data;
                    ndr_pkg::REG_LOOKAHEAD: r_lookahead <= i_cfg_data[6:0];
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                if (s_axis_tlast) begin
                    r_len  <= '0;
                    r_drop <= 1'b0;
                end else if (w_store) begin
                    r_len <= w_len_inc;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            // A new result replaces one that leaves in the same cycle.
            if (r_state == ndr_pkg::S_EADD && w_slot) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tvalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ndr_pkg::S_LOAD: begin
                if (w_in_acc && s_axis_tlast) begin
                    r_t       <= w_t_new;
                    r_ovf     <= r_drop || !w_store;
                    r_rollout <= $signed(s_axis_tdata[63:32]);
                    r_gamma   <= w_gamma;
                    r_n       <= w_n;
                    r_idx     <= AW'(w_t_new - LW'(1));
                    r_first   <= 1'b1;
                end
            end
            ndr_pkg::S_BADD: begin
                r_acc   <= w_bsum;
                r_first <= 1'b0;
                if (r_idx == '0) begin
                    r_pw <= ndr_pkg::ONE_Q16;
                    r_k  <= LW'(1);
                end else begin
                    r_idx <= r_idx - AW'(1);
                end
            end
            ndr_pkg::S_PWR: begin
                r_pw <= w_prod[16:0];
                if (r_k == r_n) begin
                    r_pn <= w_prod[16:0];
                end
                if (r_k == r_t) begin
                    r_idx <= '0;
                end else begin
                    r_k <= r_k + LW'(1);
                end
            end
            ndr_pkg::S_EADD: begin
                if (w_slot) begin
                    r_o_step <= 6'(r_idx);
                    r_o_ret  <= w_ret;
                    r_o_term <= w_term;
                    r_o_next <= w_term ? 6'd0 : 6'(w_ahead);
                    r_o_ovf  <= r_ovf;
                    r_o_last <= w_last;
                    if (!w_last) begin
                        r_idx <= r_idx + AW'(1);
                    end
                end
            end
            default: begin
            end
        endcase
    end

    ndr_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_reward_ram (
        .i_clk   (i_clk),
        .i_we    (w_in_acc && w_store),
        .i_waddr (r_len[AW-1:0]),
        .i_wdata (s_axis_tdata[31:0]),
        .i_raddr (r_idx),
        .o_rdata (w_rew_rdata)
    );

    ndr_ram #(.WIDTH(32), .DEPTH(MAX_LEN)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ndr_pkg::S_BADD),
        .i_waddr (r_idx),
        .i_wdata (w_bsum),
        .i_raddr (w_cum_raddr),
        .o_rdata (w_cum_rdata)
    );

    // Entry k-1 holds the discount raised to the power k.
    ndr_ram #(.WIDTH(17), .DEPTH(MAX_LEN)) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ndr_pkg::S_PWR),
        .i_waddr (w_k_m1[AW-1:0]),
        .i_wdata (w_prod[16:0]),
        .i_raddr (w_pw_off[AW-1:0]),
        .o_rdata (w_pw_rdata)
    );

    ndr_mul u_mul (
        .i_clk  (i_clk),
        .i_req  (w_req),
        .o_prod (w_prod)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {4'd0, r_o_next, r_o_ret, r_o_step};
    assign m_axis_tuser  = {r_o_ovf, r_o_term};
    assign m_axis_tlast  = r_o_last;

    // The last word of an episode starts the passes, so the input closes.
    a_close_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("input still open after the last word of an episode");

    // The stored episode never grows past the memory depth.
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LW'(MAX_LEN))
        else $error("episode length beyond MAX_LEN");

    // The emit pass only visits steps inside the episode.
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ndr_pkg::S_ERD) |-> (LW'(r_idx) < r_t))
        else $error("emit index outside the episode");

    // The final result of an episode hands control back to loading.
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ndr_pkg::S_EADD && w_slot && w_last) |=>
            (s_axis_tready && m_axis_tvalid && m_axis_tlast))
        else $error("final result did not end the emit pass");

endmodule

`default_nettype wire
